[hdl/hsfp_pkg.sv]
// ----------------------------------------------------------------------------
// hsfp_pkg
// shared types and constants of the heater status frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package hsfp_pkg;

  // frame layout
  localparam int unsigned FrameLen = 13;
  localparam int unsigned PosW     = 4;

  localparam logic [PosW-1:0] POS_HDR0     = 4'd0;
  localparam logic [PosW-1:0] POS_HDR1     = 4'd1;
  localparam logic [PosW-1:0] POS_HDR2     = 4'd2;
  localparam logic [PosW-1:0] POS_MODE     = 4'd3;
  localparam logic [PosW-1:0] POS_ERROR    = 4'd4;
  localparam logic [PosW-1:0] POS_INLET_H  = 4'd5;
  localparam logic [PosW-1:0] POS_INLET_L  = 4'd6;
  localparam logic [PosW-1:0] POS_OUTLET_H = 4'd7;
  localparam logic [PosW-1:0] POS_OUTLET_L = 4'd8;
  localparam logic [PosW-1:0] POS_FLOW_H   = 4'd9;
  localparam logic [PosW-1:0] POS_FLOW_L   = 4'd10;
  localparam logic [PosW-1:0] POS_CHECKSUM = 4'd11;
  localparam logic [PosW-1:0] POS_TAIL     = 4'd12;

  localparam logic [7:0] HDR0_BYTE = 8'h32;
  localparam logic [7:0] HDR1_BYTE = 8'h0F;
  localparam logic [7:0] HDR2_BYTE = 8'h01;
  localparam logic [7:0] TAIL_BYTE = 8'h34;

  // divide by ten: floor(x * 52429 / 2^19) is exact for every 16-bit x
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;
  localparam int unsigned TempW       = 13;

  // raw frame record, front to back
  typedef struct packed {
    logic        ok;
    logic [7:0]  mode;
    logic [7:0]  error;
    logic [15:0] inlet_raw;
    logic [15:0] outlet_raw;
    logic [15:0] flow;
  } frame_rec_t;

  // finished result
  typedef struct packed {
    logic             ok;
    logic [7:0]       mode;
    logic [7:0]       error;
    logic [TempW-1:0] inlet;
    logic [TempW-1:0] outlet;
    logic [15:0]      flow;
  } result_t;

endpackage

`default_nettype wire

[hdl/hsfp_front.sv]
// ----------------------------------------------------------------------------
// hsfp_front
// counts bytes into a frame, captures fields and checks header, checksum, tail
// ----------------------------------------------------------------------------
`default_nettype none

module hsfp_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic               frame_start_i,
  output hsfp_pkg::frame_rec_t    rec_o,
  output logic                    rec_valid_o
);
  import hsfp_pkg::*;

  logic [PosW-1:0] pos_q, pos_d, pos;
  logic [7:0]      xor_q, xor_d;
  logic            hdr_q, hdr_d;
  logic [7:0]      mode_q, mode_d;
  logic [7:0]      err_q, err_d;
  logic [15:0]     inlet_q, inlet_d;
  logic [15:0]     outlet_q, outlet_d;
  logic [15:0]     flow_q, flow_d;
  logic [7:0]      csum_q, csum_d;
  logic            ok;

  always_comb begin
    // out-of-range count treated as frame start
    if (frame_start_i || (pos_q > POS_TAIL)) begin
      pos = POS_HDR0;
    end else begin
      pos = pos_q;
    end
  end

  always_comb begin
    pos_d    = pos_q;
    xor_d    = xor_q;
    hdr_d    = hdr_q;
    mode_d   = mode_q;
    err_d    = err_q;
    inlet_d  = inlet_q;
    outlet_d = outlet_q;
    flow_d   = flow_q;
    csum_d   = csum_q;
    if (accept_i) begin
      pos_d = (pos == POS_TAIL) ? POS_HDR0 : pos + 4'd1;
      if ((pos >= POS_HDR1) && (pos <= POS_FLOW_L)) begin
        xor_d = xor_q ^ rx_byte_i;
      end
      case (pos)
        POS_HDR0: begin
          xor_d = 8'h00;
          hdr_d = (rx_byte_i == HDR0_BYTE);
        end
        POS_HDR1:     hdr_d = hdr_q & (rx_byte_i == HDR1_BYTE);
        POS_HDR2:     hdr_d = hdr_q & (rx_byte_i == HDR2_BYTE);
        POS_MODE:     mode_d = rx_byte_i;
        POS_ERROR:    err_d = rx_byte_i;
        POS_INLET_H:  inlet_d[15:8] = rx_byte_i;
        POS_INLET_L:  inlet_d[7:0] = rx_byte_i;
        POS_OUTLET_H: outlet_d[15:8] = rx_byte_i;
        POS_OUTLET_L: outlet_d[7:0] = rx_byte_i;
        POS_FLOW_H:   flow_d[15:8] = rx_byte_i;
        POS_FLOW_L:   flow_d[7:0] = rx_byte_i;
        POS_CHECKSUM: csum_d = rx_byte_i;
        default: ;
      endcase
    end
  end

  assign ok          = hdr_q && (csum_q == xor_q) && (rx_byte_i == TAIL_BYTE);
  assign rec_valid_o = accept_i && (pos == POS_TAIL);

  // bad frames carry zero fields
  always_comb begin
    rec_o            = '0;
    rec_o.ok         = ok;
    if (ok) begin
      rec_o.mode       = mode_q;
      rec_o.error      = err_q;
      rec_o.inlet_raw  = inlet_q;
      rec_o.outlet_raw = outlet_q;
      rec_o.flow       = flow_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      xor_q    <= '0;
      hdr_q    <= 1'b0;
      mode_q   <= '0;
      err_q    <= '0;
      inlet_q  <= '0;
      outlet_q <= '0;
      flow_q   <= '0;
      csum_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      xor_q    <= xor_d;
      hdr_q    <= hdr_d;
      mode_q   <= mode_d;
      err_q    <= err_d;
      inlet_q  <= inlet_d;
      outlet_q <= outlet_d;
      flow_q   <= flow_d;
      csum_q   <= csum_d;
    end
  end

endmodule

`default_nettype wire

[hdl/hsfp_queue.sv]
// ----------------------------------------------------------------------------
// hsfp_queue
// two-entry queue of frame records between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module hsfp_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_i,
  input  wire hsfp_pkg::frame_rec_t wr_data_i,
  output logic                      full_o,
  input  wire logic                 rd_i,
  output hsfp_pkg::frame_rec_t      rd_data_o,
  output logic                      empty_o
);
  import hsfp_pkg::*;

  frame_rec_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_wr, do_rd;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({do_wr, do_rd})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= ~wr_ptr_q;
      if (do_rd) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[hdl/hsfp_back.sv]
// ----------------------------------------------------------------------------
// hsfp_back
// scales temperatures by one tenth and buffers finished results
// ----------------------------------------------------------------------------
`default_nettype none

module hsfp_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire hsfp_pkg::frame_rec_t rec_i,
  input  wire logic                 rec_empty_i,
  output logic                      rec_pop_o,
  output hsfp_pkg::result_t         res_o,
  output logic                      empty_o,
  input  wire logic                 pop_i
);
  import hsfp_pkg::*;

  result_t     buf_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_rd;
  logic [31:0] inlet_prod, outlet_prod;
  result_t     res_new;

  assign empty_o = (cnt_q == 2'd0);
  assign do_rd   = pop_i && !empty_o;
  assign res_o   = buf_q[rd_ptr_q];

  // take a record when a slot is free or one leaves this cycle
  assign rec_pop_o = !rec_empty_i && ((cnt_q != 2'd2) || do_rd);

  assign inlet_prod  = rec_i.inlet_raw * DIV10_MUL;
  assign outlet_prod = rec_i.outlet_raw * DIV10_MUL;

  always_comb begin
    res_new.ok     = rec_i.ok;
    res_new.mode   = rec_i.mode;
    res_new.error  = rec_i.error;
    res_new.inlet  = inlet_prod[DIV10_SHIFT +: TempW];
    res_new.outlet = outlet_prod[DIV10_SHIFT +: TempW];
    res_new.flow   = rec_i.flow;
  end

  always_comb begin
    case ({rec_pop_o, do_rd})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      buf_q[wr_ptr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (rec_pop_o) wr_ptr_q <= ~wr_ptr_q;
      if (do_rd)     rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[hdl/heater_status_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// heater_status_frame_parser_core
// parses 13-byte heater status frames and emits one result per frame
// ----------------------------------------------------------------------------
//
// channel   handshake          payload
// -------   ----------------   -----------------------------------------------
// bytes in  push / full        rx_byte_i, frame_start_i
// results   empty / pop        frame_ok_o, work_mode_o, error_code_o,
//                              inlet_temp_o, outlet_temp_o, flow_rate_o
//
// one byte beat per cycle while the record queue has room; once it is full
// every byte waits, not only a tail byte
// a result is registered in the record queue at the beat of the tail byte,
// then passes the divide-by-ten multiply into the result buffer
// full rises only when the two-entry record queue is full, which needs the
// result side to hold back for whole frames
// reset clears the byte count, captures and both queues; nothing to sweep
// ----------------------------------------------------------------------------
`default_nettype none

module heater_status_frame_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte side
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        frame_start_i,
  // result side
  output logic             empty,
  input  wire logic        pop,
  output logic             frame_ok_o,
  output logic [7:0]       work_mode_o,
  output logic [7:0]       error_code_o,
  output logic [12:0]      inlet_temp_o,
  output logic [12:0]      outlet_temp_o,
  output logic [15:0]      flow_rate_o
);
  import hsfp_pkg::*;

  logic       accept;
  frame_rec_t front_rec;
  logic       front_rec_valid;
  frame_rec_t q_rec;
  logic       q_full, q_empty, q_pop;
  result_t    res;

  // byte beat taken whenever the record queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  // front: byte counting, field capture, frame checks
  hsfp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .rec_o         (front_rec),
    .rec_valid_o   (front_rec_valid)
  );

  // decouples frame ends from the result side
  hsfp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_rec_valid),
    .wr_data_i (front_rec),
    .full_o    (q_full),
    .rd_i      (q_pop),
    .rd_data_o (q_rec),
    .empty_o   (q_empty)
  );

  // back: temperature scaling and result buffer
  hsfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (q_rec),
    .rec_empty_i (q_empty),
    .rec_pop_o   (q_pop),
    .res_o       (res),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  assign frame_ok_o    = res.ok;
  assign work_mode_o   = res.mode;
  assign error_code_o  = res.error;
  assign inlet_temp_o  = res.inlet;
  assign outlet_temp_o = res.outlet;
  assign flow_rate_o   = res.flow;

endmodule

`default_nettype wire

[tb/sv/heater_status_frame_checker.sv]
// ----------------------------------------------------------------------------
// heater_status_frame_checker
// watches the byte and result channels, predicts each frame result and
// compares it with what the parser hands out
// ----------------------------------------------------------------------------

module heater_status_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  input  logic        empty,
  input  logic        pop,
  input  logic        frame_ok_i,
  input  logic [7:0]  work_mode_i,
  input  logic [7:0]  error_code_i,
  input  logic [12:0] inlet_temp_i,
  input  logic [12:0] outlet_temp_i,
  input  logic [15:0] flow_rate_i,
  output int          fail_count_o,
  output int          pending_o
);
  import hsfp_pkg::*;

  localparam logic [15:0] TEMP_DIV   = 16'd10;
  localparam int          REPORT_MAX = 10;

  // parser state as seen by the prediction
  logic [PosW-1:0] byte_pos;
  logic [7:0]      frame_xor;
  logic            header_match;
  logic [7:0]      mode_byte;
  logic [7:0]      error_byte;
  logic [15:0]     inlet_word;
  logic [15:0]     outlet_word;
  logic [15:0]     flow_word;
  logic [7:0]      checksum_byte;

  result_t frame_results_q[$];
  result_t seen_result;
  result_t want_result;
  int      frame_errors;

  task automatic clear_parser_state();
    byte_pos      = POS_HDR0;
    frame_xor     = '0;
    header_match  = 1'b0;
    mode_byte     = '0;
    error_byte    = '0;
    inlet_word    = '0;
    outlet_word   = '0;
    flow_word     = '0;
    checksum_byte = '0;
  endtask

  // one byte through the frame parser; a tail byte queues one result
  task automatic parse_status_byte(input logic [7:0] b, input logic start);
    logic [PosW-1:0] p;
    result_t         r;
    p = start ? POS_HDR0 : byte_pos;
    if (p > POS_TAIL) p = POS_HDR0;
    if (p >= POS_HDR1 && p <= POS_FLOW_L) frame_xor = frame_xor ^ b;
    case (p)
      POS_HDR0: begin
        frame_xor    = '0;
        header_match = (b == HDR0_BYTE);
      end
      POS_HDR1:     header_match = header_match & (b == HDR1_BYTE);
      POS_HDR2:     header_match = header_match & (b == HDR2_BYTE);
      POS_MODE:     mode_byte = b;
      POS_ERROR:    error_byte = b;
      POS_INLET_H:  inlet_word[15:8] = b;
      POS_INLET_L:  inlet_word[7:0] = b;
      POS_OUTLET_H: outlet_word[15:8] = b;
      POS_OUTLET_L: outlet_word[7:0] = b;
      POS_FLOW_H:   flow_word[15:8] = b;
      POS_FLOW_L:   flow_word[7:0] = b;
      POS_CHECKSUM: checksum_byte = b;
      default: ;
    endcase
    if (p == POS_TAIL) begin
      byte_pos = POS_HDR0;
      r = '0;
      if (header_match && checksum_byte == frame_xor && b == TAIL_BYTE) begin
        r.ok     = 1'b1;
        r.mode   = mode_byte;
        r.error  = error_byte;
        r.inlet  = TempW'(inlet_word / TEMP_DIV);
        r.outlet = TempW'(outlet_word / TEMP_DIV);
        r.flow   = flow_word;
      end
      frame_results_q.push_back(r);
    end else begin
      byte_pos = p + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser_state();
      frame_results_q.delete();
      frame_errors = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // results first: a result leaving now never belongs to this byte
      if (pop && !empty) begin
        seen_result.ok     = frame_ok_i;
        seen_result.mode   = work_mode_i;
        seen_result.error  = error_code_i;
        seen_result.inlet  = inlet_temp_i;
        seen_result.outlet = outlet_temp_i;
        seen_result.flow   = flow_rate_i;
        if (frame_results_q.size() == 0) begin
          frame_errors++;
          if (frame_errors <= REPORT_MAX)
            $display("%0t: result with no frame pending:", $realtime,
                     " ok=%0d mode=%h err=%h in=%0d out=%0d flow=%0d",
                     seen_result.ok, seen_result.mode, seen_result.error,
                     seen_result.inlet, seen_result.outlet, seen_result.flow);
        end else begin
          want_result = frame_results_q.pop_front();
          if (seen_result.ok !== want_result.ok || seen_result.mode !== want_result.mode ||
              seen_result.error !== want_result.error ||
              seen_result.inlet !== want_result.inlet ||
              seen_result.outlet !== want_result.outlet ||
              seen_result.flow !== want_result.flow) begin
            frame_errors++;
            if (frame_errors <= REPORT_MAX) begin
              $display("%0t: frame result mismatch", $realtime);
              $display("  expected ok=%0d mode=%h err=%h in=%0d out=%0d flow=%0d",
                       want_result.ok, want_result.mode, want_result.error,
                       want_result.inlet, want_result.outlet, want_result.flow);
              $display("  actual   ok=%0d mode=%h err=%h in=%0d out=%0d flow=%0d",
                       seen_result.ok, seen_result.mode, seen_result.error,
                       seen_result.inlet, seen_result.outlet, seen_result.flow);
            end
          end
        end
      end
      if (push && !full) parse_status_byte(rx_byte_i, frame_start_i);
      fail_count_o <= frame_errors;
      pending_o    <= frame_results_q.size();
    end
  end

endmodule

[tb/sv/heater_status_frame_parser_core_tb.sv]
// ----------------------------------------------------------------------------
// heater_status_frame_parser_core_tb
// feeds directed and random status frames, clean and damaged, into the
// parser with random gaps on both sides and a long result stall; the
// checker predicts every frame result and counts mismatches
// ----------------------------------------------------------------------------

module heater_status_frame_parser_core_tb;

  import hsfp_pkg::*;

  localparam int RESET_CYCLES   = 8;
  localparam int PHASE_BYTES    = 540;  // three phases, about 1600 beats
  localparam int HOLD_CYCLES    = 400;  // long result stall to fill the parser
  localparam int DRAIN_CYCLES   = 20;   // result passes record queue and result buffer after the tail
  localparam int WATCHDOG_LIMIT = 4000; // cycles without any accepted beat

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  rx_byte_i;
  logic        frame_start_i;
  logic        empty;
  logic        pop;
  logic        frame_ok_o;
  logic [7:0]  work_mode_o;
  logic [7:0]  error_code_o;
  logic [12:0] inlet_temp_o;
  logic [12:0] outlet_temp_o;
  logic [15:0] flow_rate_o;

  int fail_count;
  int pending_frames;

  // idle shares in percent, set per phase by the stimulus
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_off_req;

  int         bytes_sent;
  logic [7:0] frame_buf [FrameLen];
  logic       frame_aligned;

  heater_status_frame_parser_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .empty         (empty),
    .pop           (pop),
    .frame_ok_o    (frame_ok_o),
    .work_mode_o   (work_mode_o),
    .error_code_o  (error_code_o),
    .inlet_temp_o  (inlet_temp_o),
    .outlet_temp_o (outlet_temp_o),
    .flow_rate_o   (flow_rate_o)
  );

  heater_status_frame_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .empty         (empty),
    .pop           (pop),
    .frame_ok_i    (frame_ok_o),
    .work_mode_i   (work_mode_o),
    .error_code_i  (error_code_o),
    .inlet_temp_i  (inlet_temp_o),
    .outlet_temp_i (outlet_temp_o),
    .flow_rate_i   (flow_rate_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_frames)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // one byte beat: random gaps first, then hold push until full is low at an edge
  task automatic send_byte(input logic [7:0] b, input logic start);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push          <= 1'b1;
    rx_byte_i     <= b;
    frame_start_i <= start;
    do @(posedge clk_i); while (full);
    bytes_sent++;
  endtask

  // first n bytes of frame_buf, start flag only on the first one
  task automatic send_frame_bytes(input int n, input logic first_start);
    for (int i = 0; i < n; i++)
      send_byte(frame_buf[i], (i == 0) ? first_start : 1'b0);
  endtask

  // field values lean on the extremes now and then
  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(19));
      default: return 16'($urandom);
    endcase
  endfunction

  // well-formed frame with given fields and a matching checksum
  task automatic build_status_frame(input logic [7:0] mode, input logic [7:0] err,
                                    input logic [15:0] inlet, input logic [15:0] outlet,
                                    input logic [15:0] flow);
    logic [7:0] x;
    frame_buf[POS_HDR0]     = HDR0_BYTE;
    frame_buf[POS_HDR1]     = HDR1_BYTE;
    frame_buf[POS_HDR2]     = HDR2_BYTE;
    frame_buf[POS_MODE]     = mode;
    frame_buf[POS_ERROR]    = err;
    frame_buf[POS_INLET_H]  = inlet[15:8];
    frame_buf[POS_INLET_L]  = inlet[7:0];
    frame_buf[POS_OUTLET_H] = outlet[15:8];
    frame_buf[POS_OUTLET_L] = outlet[7:0];
    frame_buf[POS_FLOW_H]   = flow[15:8];
    frame_buf[POS_FLOW_L]   = flow[7:0];
    x = '0;
    for (int i = POS_HDR1; i <= POS_FLOW_L; i++) x = x ^ frame_buf[i];
    frame_buf[POS_CHECKSUM] = x;
    frame_buf[POS_TAIL]     = TAIL_BYTE;
  endtask

  // mostly clean frames with random content, the rest damaged, cut short or noise
  task automatic send_random_frame();
    int   kind;
    int   n;
    logic start;
    build_status_frame(8'(pick_word() >> 8), 8'(pick_word() >> 8), pick_word(),
                       pick_word(), pick_word());
    // a realigning start flag is needed after a cut or noise, optional otherwise
    start = frame_aligned ? 1'($urandom_range(1)) : 1'b1;
    kind  = $urandom_range(99);
    if (kind < 65) begin
      send_frame_bytes(FrameLen, start);
      frame_aligned = 1'b1;
    end else if (kind < 72) begin
      // broken header byte
      n = $urandom_range(POS_HDR2);
      frame_buf[n] = frame_buf[n] ^ 8'($urandom_range(1, 255));
      send_frame_bytes(FrameLen, start);
      frame_aligned = 1'b1;
    end else if (kind < 79) begin
      // checksum off
      frame_buf[POS_CHECKSUM] = frame_buf[POS_CHECKSUM] ^ 8'($urandom_range(1, 255));
      send_frame_bytes(FrameLen, start);
      frame_aligned = 1'b1;
    end else if (kind < 86) begin
      // tail off
      frame_buf[POS_TAIL] = frame_buf[POS_TAIL] ^ 8'($urandom_range(1, 255));
      send_frame_bytes(FrameLen, start);
      frame_aligned = 1'b1;
    end else if (kind < 93) begin
      // cut short, the next frame restarts mid-frame
      send_frame_bytes($urandom_range(1, FrameLen - 1), start);
      frame_aligned = 1'b0;
    end else begin
      // line noise with stray start flags
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom), ($urandom_range(4) == 0));
      frame_aligned = 1'b0;
    end
  endtask

  // result side: random pop, plus one long counted hold-off when asked
  initial begin : result_drain
    int hold_left;
    pop       = 1'b0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: too long without any accepted beat on either side
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    push          = 1'b0;
    rx_byte_i     = '0;
    frame_start_i = 1'b0;
    hold_off_req  = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 73;
    bytes_sent    = 0;
    frame_aligned = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: a cut-off header, then a restart mid-frame with every field at
    // its top value, then a zero frame that follows with no start flag
    build_status_frame(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_frame_bytes(POS_MODE, 1'b1);
    send_frame_bytes(FrameLen, 1'b1);
    build_status_frame(8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    send_frame_bytes(FrameLen, 1'b0);
    frame_aligned = 1'b1;

    // random phases: sender rarely idle, then receiver rarely idle, then neither
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // results stall for a long stretch while frames keep coming
          hold_off_req  = 1'b1;
        end
      endcase
      while (bytes_sent < (phase + 1) * PHASE_BYTES) send_random_frame();
    end

    @(negedge clk_i);
    push <= 1'b0;

    // wait out every pending result, then a few cycles for strays
    while (pending_frames != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending_frames == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
